[rtl/core/rotation_basis_orthonormalize_macros.svh]
// Assertion macros shared by the rotation basis orthonormalizer RTL.
`ifndef ROTATION_BASIS_ORTHONORMALIZE_MACROS_SVH
`define ROTATION_BASIS_ORTHONORMALIZE_MACROS_SVH

// Same-cycle implication, switched off while reset is asserted.
`define RBO_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication that is also checked during reset.
`define RBO_ASSERT_NEXT(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/rbo_pkg.sv]
// Shared types and constants for the rotation basis orthonormalizer.
package rbo_pkg;

    localparam int Q14_W   = 16;
    localparam int PROD_W  = 30;
    localparam int CROSS_W = 31;
    localparam int VEC_W   = 3 * Q14_W;

    localparam logic [Q14_W-1:0] ONE_Q14 = 16'd16384;

    typedef logic [2:0][Q14_W-1:0]   t_vec;
    typedef logic [2:0][CROSS_W-1:0] t_cross;

endpackage

[rtl/core/rbo_norm.sv]
// Pipelined vector normalizer: magnitude alignment, squares, square root, division.
module rbo_norm
    import rbo_pkg::*;
#(
    parameter int IW = 16,
    parameter int SW = 1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [2:0][IW-1:0]  i_vec,
    input  logic [SW-1:0]       i_sb,
    output logic                o_valid,
    input  logic                i_ready,
    output t_vec                o_vec,
    output logic                o_zero,
    output logic [SW-1:0]       o_sb
);

    localparam int MW  = 32;
    localparam int LW  = 64;
    localparam int QW  = 15;
    localparam int DW  = MW + 1;
    localparam int NW  = MW + QW;
    localparam int SHF0   = 1;
    localparam int SQ     = 6;
    localparam int SUM    = 7;
    localparam int RT0    = 8;
    localparam int DVINIT = RT0 + MW;
    localparam int DV0    = DVINIT + 1;
    localparam int FIN    = DV0 + QW;
    localparam int NST    = FIN + 1;

    typedef struct packed {
        logic [SW-1:0]        sb;
        logic                 zero;
        logic [2:0]           neg;
        logic [2:0][MW-1:0]   m;
        logic [MW-1:0]        big;
        logic [2:0][LW-1:0]   p;
        logic [LW-1:0]        v;
        logic [LW-1:0]        r;
        logic [2:0][NW-1:0]   rem;
        logic [DW-1:0]        d;
        logic [2:0][QW-1:0]   q;
        t_vec                 nv;
    } t_nst;

    t_nst           r_st [NST];
    t_nst           n_st [NST];
    logic [NST-1:0] r_v;
    logic [NST-1:0] w_vin;
    logic [NST:0]   w_rdy;

    assign w_vin      = {r_v[NST-2:0], i_valid};
    assign w_rdy[NST] = i_ready;

    for (genvar k = 0; k < NST; k++) begin : g_st
        assign w_rdy[k] = !r_v[k] || w_rdy[k+1];

        if (k == 0) begin : g_abs
            always_comb begin
                logic [IW-1:0] mag;
                logic [MW-1:0] big;
                n_st[k] = '0;
                n_st[k].sb = i_sb;
                big = '0;
                for (int i = 0; i < 3; i++) begin
                    n_st[k].neg[i] = i_vec[i][IW-1];
                    mag = i_vec[i][IW-1] ? (~i_vec[i] + IW'(1)) : i_vec[i];
                    n_st[k].m[i] = MW'(mag);
                    if (MW'(mag) > big) begin
                        big = MW'(mag);
                    end
                end
                n_st[k].big  = big;
                n_st[k].zero = (big == '0);
            end
        end else if (k < SQ) begin : g_shift
            // Binary alignment: shift while the top bits stay clear of bit 31.
            localparam int SH = 16 >> (k - SHF0);
            always_comb begin
                n_st[k] = r_st[k-1];
                if (r_st[k-1].big[MW-1 -: SH+1] == '0) begin
                    n_st[k].big = r_st[k-1].big << SH;
                    for (int i = 0; i < 3; i++) begin
                        n_st[k].m[i] = r_st[k-1].m[i] << SH;
                    end
                end
            end
        end else if (k == SQ) begin : g_sq
            always_comb begin
                n_st[k] = r_st[k-1];
                for (int i = 0; i < 3; i++) begin
                    n_st[k].p[i] = LW'(r_st[k-1].m[i]) * LW'(r_st[k-1].m[i]);
                end
            end
        end else if (k == SUM) begin : g_sum
            always_comb begin
                n_st[k] = r_st[k-1];
                n_st[k].v = r_st[k-1].p[0] + r_st[k-1].p[1] + r_st[k-1].p[2];
                n_st[k].r = '0;
            end
        end else if (k < DVINIT) begin : g_root
            localparam logic [LW-1:0] BIT = LW'(1) << ((LW - 2) - 2 * (k - RT0));
            always_comb begin
                logic [LW-1:0] trial;
                n_st[k] = r_st[k-1];
                trial = r_st[k-1].r + BIT;
                if (r_st[k-1].v >= trial) begin
                    n_st[k].v = r_st[k-1].v - trial;
                    n_st[k].r = (r_st[k-1].r >> 1) + BIT;
                end else begin
                    n_st[k].r = r_st[k-1].r >> 1;
                end
            end
        end else if (k == DVINIT) begin : g_dinit
            // Dividend is mag * 2^15 + s, divisor 2 * s: rounds to nearest.
            always_comb begin
                logic [MW-1:0] s;
                n_st[k] = r_st[k-1];
                s = r_st[k-1].r[MW-1:0];
                n_st[k].d = {s, 1'b0};
                for (int i = 0; i < 3; i++) begin
                    n_st[k].rem[i] = {r_st[k-1].m[i], {QW{1'b0}}} + NW'(s);
                    n_st[k].q[i]   = '0;
                end
            end
        end else if (k < FIN) begin : g_div
            localparam int QB = QW - 1 - (k - DV0);
            always_comb begin
                logic [NW-1:0] dsh;
                n_st[k] = r_st[k-1];
                dsh = NW'(r_st[k-1].d) << QB;
                for (int i = 0; i < 3; i++) begin
                    if (r_st[k-1].rem[i] >= dsh) begin
                        n_st[k].rem[i]   = r_st[k-1].rem[i] - dsh;
                        n_st[k].q[i][QB] = 1'b1;
                    end
                end
            end
        end else begin : g_fin
            always_comb begin
                logic [Q14_W-1:0] qs;
                n_st[k] = r_st[k-1];
                for (int i = 0; i < 3; i++) begin
                    qs = {1'b0, r_st[k-1].q[i]};
                    if (qs > ONE_Q14) begin
                        qs = ONE_Q14;
                    end
                    n_st[k].nv[i] = r_st[k-1].neg[i] ? (~qs + Q14_W'(1)) : qs;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= (w_vin & w_rdy[NST-1:0]) | (r_v & ~w_rdy[NST-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NST; k++) begin
            if (w_rdy[k]) begin
                r_st[k] <= n_st[k];
            end
        end
    end

    assign o_ready = w_rdy[0];
    assign o_valid = r_v[NST-1];
    assign o_vec   = r_st[NST-1].nv;
    assign o_zero  = r_st[NST-1].zero;
    assign o_sb    = r_st[NST-1].sb;

endmodule

[rtl/core/rbo_cross.sv]
// Two-stage pipelined cross product of two Q1.14 vectors into exact Q2.28.
module rbo_cross
    import rbo_pkg::*;
#(
    parameter int SW = 1
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  t_vec           i_a,
    input  t_vec           i_b,
    input  logic [SW-1:0]  i_sb,
    output logic           o_valid,
    input  logic           i_ready,
    output t_cross         o_c,
    output logic [SW-1:0]  o_sb
);

    localparam int NST = 2;

    typedef struct packed {
        logic [SW-1:0]          sb;
        logic [5:0][PROD_W-1:0] p;
        t_cross                 c;
    } t_cst;

    t_cst           r_st [NST];
    t_cst           n_st [NST];
    logic [NST-1:0] r_v;
    logic [NST-1:0] w_vin;
    logic [NST:0]   w_rdy;

    assign w_vin      = {r_v[NST-2:0], i_valid};
    assign w_rdy[NST] = i_ready;

    for (genvar k = 0; k < NST; k++) begin : g_rdy
        assign w_rdy[k] = !r_v[k] || w_rdy[k+1];
    end

    always_comb begin
        n_st[0]      = '0;
        n_st[0].sb   = i_sb;
        n_st[0].p[0] = PROD_W'($signed(i_a[1]) * $signed(i_b[2]));
        n_st[0].p[1] = PROD_W'($signed(i_a[2]) * $signed(i_b[1]));
        n_st[0].p[2] = PROD_W'($signed(i_a[2]) * $signed(i_b[0]));
        n_st[0].p[3] = PROD_W'($signed(i_a[0]) * $signed(i_b[2]));
        n_st[0].p[4] = PROD_W'($signed(i_a[0]) * $signed(i_b[1]));
        n_st[0].p[5] = PROD_W'($signed(i_a[1]) * $signed(i_b[0]));
    end

    always_comb begin
        n_st[1] = r_st[0];
        for (int i = 0; i < 3; i++) begin
            n_st[1].c[i] = CROSS_W'($signed(r_st[0].p[2*i]))
                         - CROSS_W'($signed(r_st[0].p[2*i+1]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= (w_vin & w_rdy[NST-1:0]) | (r_v & ~w_rdy[NST-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NST; k++) begin
            if (w_rdy[k]) begin
                r_st[k] <= n_st[k];
            end
        end
    end

    assign o_ready = w_rdy[0];
    assign o_valid = r_v[NST-1];
    assign o_c     = r_st[NST-1].c;
    assign o_sb    = r_st[NST-1].sb;

endmodule

[rtl/core/rotation_basis_orthonormalize.sv]
// Throughput: one transaction per cycle unless the output stalls; every normalizer
// stage is a register stage (32 square-root steps and 15 division steps per normalizer),
// so nothing iterates.
// Each stage has a valid bit and collapses bubbles, so input is taken while a result waits.
// Reset (i_rst_n low, synchronous) clears all valid bits; payload registers are not reset.
`include "rotation_basis_orthonormalize_macros.svh"

module rotation_basis_orthonormalize
    import rbo_pkg::*;
#(
    parameter int COMPONENT_WIDTH = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Slave side.
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // tdata, lowest bits first: up_x, up_y, up_z, fwd_x, fwd_y, fwd_z, zero fill.
    input  logic [((6*COMPONENT_WIDTH+7)/8)*8-1:0] i_s_axis_tdata,
    // Master side.
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // tdata, lowest bits first: right_x, right_y, right_z, newup_x, newup_y, newup_z,
    // face_x, face_y, face_z.
    output logic [9*Q14_W-1:0]    o_m_axis_tdata,
    // tuser: degenerate.
    output logic [0:0]            o_m_axis_tuser
);

    localparam int CW       = COMPONENT_WIDTH;
    localparam int OUT_W    = 9 * Q14_W;
    localparam int SB1_W    = 3 * CW;
    localparam int SB2_W    = VEC_W + 1;
    localparam int SB5_W    = 2 * VEC_W + 1;
    localparam int FRAC_SH  = 14;
    localparam int RQ_W     = CROSS_W - FRAC_SH + 1;

    // Identity payload with right = x, new up = y and face = z.
    localparam logic [OUT_W-1:0] IDENT =
        (OUT_W'(ONE_Q14)) | (OUT_W'(ONE_Q14) << (4 * Q14_W)) | (OUT_W'(ONE_Q14) << (8 * Q14_W));

    logic [2:0][CW-1:0] w_up;
    logic [2:0][CW-1:0] w_fw_in;

    assign w_up = i_s_axis_tdata[3*CW-1:0];

    // Stage group 1: normalize up, carry the raw forward row alongside.
    logic             w_v1, w_r1;
    t_vec             w_un;
    logic             w_zu;
    logic [SB1_W-1:0] w_sb1;

    rbo_norm #(.IW(CW), .SW(SB1_W)) u_norm_up (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_vec   (w_up),
        .i_sb    (i_s_axis_tdata[6*CW-1:3*CW]),
        .o_valid (w_v1),
        .i_ready (w_r1),
        .o_vec   (w_un),
        .o_zero  (w_zu),
        .o_sb    (w_sb1)
    );

    assign w_fw_in = w_sb1;

    // Stage group 2: normalize forward, carry the unit up row and its zero flag.
    logic             w_v2, w_r2;
    t_vec             w_fn;
    logic             w_zf;
    logic [SB2_W-1:0] w_sb2;

    rbo_norm #(.IW(CW), .SW(SB2_W)) u_norm_fw (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_v1),
        .o_ready (w_r1),
        .i_vec   (w_fw_in),
        .i_sb    ({w_un, w_zu}),
        .o_valid (w_v2),
        .i_ready (w_r2),
        .o_vec   (w_fn),
        .o_zero  (w_zf),
        .o_sb    (w_sb2)
    );

    // Stage group 3: right = up x forward in exact Q2.28.
    logic             w_v3, w_r3;
    t_cross           w_rc;
    logic [SB2_W-1:0] w_sb3;

    rbo_cross #(.SW(SB2_W)) u_cross_rt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_v2),
        .o_ready (w_r2),
        .i_a     (w_sb2[SB2_W-1:1]),
        .i_b     (w_fn),
        .i_sb    ({w_fn, w_sb2[0] | w_zf}),
        .o_valid (w_v3),
        .i_ready (w_r3),
        .o_c     (w_rc),
        .o_sb    (w_sb3)
    );

    // Stage group 4: normalize right. A zero right vector means parallel inputs.
    logic             w_v4, w_r4;
    t_vec             w_rn;
    logic             w_zr;
    logic [SB2_W-1:0] w_sb4;

    rbo_norm #(.IW(CROSS_W), .SW(SB2_W)) u_norm_rt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_v3),
        .o_ready (w_r3),
        .i_vec   (w_rc),
        .i_sb    (w_sb3),
        .o_valid (w_v4),
        .i_ready (w_r4),
        .o_vec   (w_rn),
        .o_zero  (w_zr),
        .o_sb    (w_sb4)
    );

    // Stage group 5: new up = forward x right.
    logic             w_v5, w_fin_rdy;
    t_cross           w_nu;
    logic [SB5_W-1:0] w_sb5;

    rbo_cross #(.SW(SB5_W)) u_cross_up (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_v4),
        .o_ready (w_r4),
        .i_a     (w_sb4[SB2_W-1:1]),
        .i_b     (w_rn),
        .i_sb    ({w_rn, w_sb4[SB2_W-1:1], w_sb4[0] | w_zr}),
        .o_valid (w_v5),
        .i_ready (w_fin_rdy),
        .o_c     (w_nu),
        .o_sb    (w_sb5)
    );

    // Output stage: round new up to Q1.14 (half away from zero, saturated),
    // substitute the identity for degenerate inputs, and hold the result.
    logic             r_ov;
    logic [OUT_W-1:0] r_od;
    logic             r_ou;
    logic [OUT_W-1:0] n_od;
    t_vec             w_nuq;

    always_comb begin
        logic [CROSS_W-1:0] mag;
        logic [RQ_W-1:0]    rq;
        logic [Q14_W-1:0]   qv;
        for (int i = 0; i < 3; i++) begin
            mag = w_nu[i][CROSS_W-1] ? (~w_nu[i] + CROSS_W'(1)) : w_nu[i];
            rq  = RQ_W'((mag + (CROSS_W'(1) << (FRAC_SH - 1))) >> FRAC_SH);
            if (rq > RQ_W'(ONE_Q14)) begin
                qv = ONE_Q14;
            end else begin
                qv = Q14_W'(rq);
            end
            w_nuq[i] = w_nu[i][CROSS_W-1] ? (~qv + Q14_W'(1)) : qv;
        end
        if (w_sb5[0]) begin
            n_od = IDENT;
        end else begin
            n_od = {w_sb5[SB5_W-VEC_W-1:1], w_nuq, w_sb5[SB5_W-1:SB5_W-VEC_W]};
        end
    end

    assign w_fin_rdy = !r_ov || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_fin_rdy) begin
            r_ov <= w_v5;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fin_rdy) begin
            r_od <= n_od;
            r_ou <= w_sb5[0];
        end
    end

    assign o_m_axis_tvalid   = r_ov;
    assign o_m_axis_tdata    = r_od;
    assign o_m_axis_tuser[0] = r_ou;

    // A degenerate result must carry exactly the identity rows.
    `RBO_ASSERT_IMP(a_degen_ident, i_clk, i_rst_n, o_m_axis_tvalid && o_m_axis_tuser[0], o_m_axis_tdata == IDENT, "degenerate result is not the identity")
    // A regular result has a right row that came from a nonzero cross product.
    `RBO_ASSERT_IMP(a_right_live, i_clk, i_rst_n, o_m_axis_tvalid && !o_m_axis_tuser[0], o_m_axis_tdata[VEC_W-1:0] != '0, "right row is zero on a regular result")
    // Reset empties the output register.
    `RBO_ASSERT_NEXT(a_rst_empty, i_clk, !i_rst_n, !o_m_axis_tvalid, "output valid after reset")

endmodule

[tb/rotation_basis_orthonormalize_tb.sv]
// Self-checking stream testbench for the rotation basis orthonormalizer.
`timescale 1ns / 100ps

module rotation_basis_orthonormalize_tb;
    import rbo_pkg::*;

    localparam int CW      = 16;
    localparam int IN_W    = ((6 * CW + 7) / 8) * 8;
    localparam int LATENCY = 176;
    localparam int N_RAND  = 700;

    typedef longint t_vec3 [3];

    // One matrix request: up row then forward row.
    typedef struct {
        longint up [3];
        longint fwd [3];
    } t_basis_req;

    // One expected matrix: nine Q1.14 entries plus the degenerate flag.
    typedef struct {
        logic [Q14_W-1:0] rows [9];
        logic             degen;
    } t_basis_exp;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_s_axis_tvalid;
    logic                 o_s_axis_tready;
    // tdata, lowest bits first: up_x, up_y, up_z, fwd_x, fwd_y, fwd_z, zero fill.
    logic [IN_W-1:0]      i_s_axis_tdata;
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready;
    // tdata, lowest bits first: right_x .. face_z.
    logic [9*Q14_W-1:0]   o_m_axis_tdata;
    // tuser: degenerate.
    logic [0:0]           o_m_axis_tuser;

    t_basis_req pending_reqs [$];
    t_basis_exp expected_bases [$];
    t_basis_req cur_req;

    int  n_sent;
    int  n_checked;
    int  n_degen;
    int  n_errors;
    int  src_gap;
    int  sink_stall;
    int  hold_left;
    bit  hold_done;
    bit  src_burst;
    bit  sink_burst;

    string field_names [10] = '{"right_x", "right_y", "right_z", "newup_x", "newup_y",
                                "newup_z", "face_x", "face_y", "face_z", "degenerate"};

    rotation_basis_orthonormalize #(.COMPONENT_WIDTH(CW)) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // Bitwise integer square root, floor of the true root.
    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Scales a vector to unit length in Q1.14. Returns 0 for the zero vector.
    function automatic bit to_unit(input t_vec3 c, output t_vec3 n);
        longint unsigned m [3];
        longint unsigned big;
        longint unsigned l2;
        longint unsigned s;
        longint unsigned q;
        big = 0;
        n = '{0, 0, 0};
        for (int i = 0; i < 3; i++) begin
            m[i] = (c[i] < 0) ? longint'(-c[i]) : longint'(c[i]);
            if (m[i] > big) big = m[i];
        end
        if (big == 0) return 1'b0;
        // Shift all magnitudes together until the largest reaches 2^30.
        while (big < (64'd1 << 30)) begin
            big = big << 1;
            for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
        end
        l2 = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
        s = int_sqrt(l2);
        for (int i = 0; i < 3; i++) begin
            q = (m[i] * 64'd32768 + s) / (2 * s);
            if (q > 16384) q = 16384;
            n[i] = (c[i] < 0) ? -longint'(q) : longint'(q);
        end
        return 1'b1;
    endfunction

    function automatic t_vec3 cross3(input t_vec3 a, input t_vec3 b);
        t_vec3 r;
        r[0] = a[1] * b[2] - a[2] * b[1];
        r[1] = a[2] * b[0] - a[0] * b[2];
        r[2] = a[0] * b[1] - a[1] * b[0];
        return r;
    endfunction

    // Q2.28 to Q1.14, rounding half away from zero and saturating.
    function automatic longint q28_round(input longint v);
        longint unsigned q;
        q = (((v < 0) ? -v : v) + 8192) >> 14;
        if (q > 16384) q = 16384;
        return (v < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic t_basis_exp predict_basis(input t_basis_req rq);
        t_basis_exp e;
        t_vec3 up_s, fwd_s, up_n, fwd_n, rgt_c, rgt_n, nup;
        bit ok;
        // The block sees only the low CW bits of each component, as signed values.
        for (int i = 0; i < 3; i++) begin
            up_s[i]  = longint'($signed(rq.up[i][CW-1:0]));
            fwd_s[i] = longint'($signed(rq.fwd[i][CW-1:0]));
        end
        ok = to_unit(up_s, up_n);
        if (ok) ok = to_unit(fwd_s, fwd_n);
        if (ok) begin
            rgt_c = cross3(up_n, fwd_n);
            // A zero cross product means the rows are parallel.
            ok = to_unit(rgt_c, rgt_n);
        end
        if (ok) begin
            nup = cross3(fwd_n, rgt_n);
            for (int i = 0; i < 3; i++) begin
                e.rows[i]     = rgt_n[i][15:0];
                e.rows[3 + i] = Q14_W'(q28_round(nup[i]));
                e.rows[6 + i] = fwd_n[i][15:0];
            end
            e.degen = 1'b0;
        end else begin
            for (int i = 0; i < 9; i++) e.rows[i] = '0;
            e.rows[0] = ONE_Q14;
            e.rows[4] = ONE_Q14;
            e.rows[8] = ONE_Q14;
            e.degen = 1'b1;
        end
        return e;
    endfunction

    function automatic logic [IN_W-1:0] pack_req(input t_basis_req rq);
        logic [IN_W-1:0] d;
        d = '0;
        for (int i = 0; i < 3; i++) begin
            d[i*CW +: CW]       = rq.up[i][CW-1:0];
            d[(3+i)*CW +: CW]   = rq.fwd[i][CW-1:0];
        end
        return d;
    endfunction

    function automatic longint rnd_comp();
        return longint'($urandom_range(0, 65535)) - 32768;
    endfunction

    function automatic longint rnd_small();
        return longint'($urandom_range(0, 64)) - 32;
    endfunction

    task automatic add_req(input longint ux, input longint uy, input longint uz,
                           input longint fx, input longint fy, input longint fz);
        t_basis_req rq;
        rq.up  = '{ux, uy, uz};
        rq.fwd = '{fx, fy, fz};
        pending_reqs.push_back(rq);
    endtask

    function automatic int draw_wait(input bit burst);
        if (burst) return 0;
        return $urandom_range(0, 14);
    endfunction

    // Stimulus: directed corners first, then mostly random matrices with a
    // share of parallel, zero, small and partly zeroed rows to keep hitting the
    // degenerate path.
    initial begin
        longint k;
        int sel;
        add_req(0, 0, 0, 0, 0, 0);
        add_req(0, 0, 0, 0, 4096, 0);
        add_req(0, 4096, 0, 0, 0, 0);
        add_req(0, 4096, 0, 0, 0, 4096);
        add_req(0, 4096, 0, 0, 4096, 0);
        add_req(0, 4096, 0, 0, -4096, 0);
        add_req(-32768, -32768, -32768, 32767, 32767, 32767);
        add_req(32767, 0, 0, 0, -32768, 0);
        add_req(-32768, 0, 0, 0, 0, -32768);
        add_req(32767, 32767, 32767, -32768, 0, 32767);
        add_req(1, 0, 0, 0, 1, 0);
        add_req(1, 1, 1, -1, -1, 1);
        add_req(-1, -1, -1, 1, 1, 1);
        add_req(100, 200, 300, 200, 400, 600);
        add_req(4096, 4096, 0, 4096, 4000, 0);
        add_req(21845, -10922, 5461, -32768, 32767, -1);
        add_req(-21846, 10921, -5462, 32767, -32768, 0);
        add_req(0, 0, 1, 0, 0, -32768);
        add_req(43, -7, 32767, 32767, 43, -7);
        add_req(16384, -16384, 8192, -8192, 8192, 16384);
        for (int n = 0; n < N_RAND; n++) begin
            t_basis_req rq;
            sel = $urandom_range(0, 19);
            for (int i = 0; i < 3; i++) begin
                rq.up[i]  = rnd_comp();
                rq.fwd[i] = rnd_comp();
            end
            if (sel == 0) begin
                // Forward is a scaled copy of up, possibly negated.
                k = $urandom_range(0, 1) ? 1 : -1;
                for (int i = 0; i < 3; i++) begin
                    rq.up[i] = rnd_small() * 512;
                    rq.fwd[i] = rq.up[i] * k * longint'($urandom_range(1, 2));
                end
            end else if (sel == 1) begin
                rq.up = '{0, 0, 0};
            end else if (sel == 2) begin
                rq.fwd = '{0, 0, 0};
            end else if (sel <= 5) begin
                for (int i = 0; i < 3; i++) begin
                    rq.up[i]  = rnd_small();
                    rq.fwd[i] = rnd_small();
                end
            end else if (sel == 6) begin
                rq.up[$urandom_range(0, 2)] = 0;
                rq.fwd[$urandom_range(0, 2)] = 0;
            end
            pending_reqs.push_back(rq);
        end
    end

    initial begin
        i_rst_n = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Source side: holds an item until it is taken, then waits a drawn gap.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
            i_s_axis_tdata  <= '0;
            src_gap         <= 0;
            src_burst       <= 1'b0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                expected_bases.push_back(predict_basis(cur_req));
                n_sent = n_sent + 1;
                if (n_sent % 97 == 0) src_burst <= ~src_burst;
            end
            if (!i_s_axis_tvalid || o_s_axis_tready) begin
                if (src_gap > 0) begin
                    src_gap         <= src_gap - 1;
                    i_s_axis_tvalid <= 1'b0;
                end else if (pending_reqs.size() > 0) begin
                    cur_req = pending_reqs.pop_front();
                    i_s_axis_tdata  <= pack_req(cur_req);
                    i_s_axis_tvalid <= 1'b1;
                    src_gap         <= draw_wait(src_burst);
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Sink side: checks each accepted transaction against the oldest
    // prediction and throttles tready. One long hold-off fills the pipeline
    // so the block must back-pressure its input.
    always @(posedge i_clk) begin
        t_basis_exp e;
        logic nxt_ready;
        int wait_cycles;
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
            sink_stall      <= 0;
            hold_left       <= 0;
            hold_done       <= 1'b0;
            sink_burst      <= 1'b1;
        end else begin
            nxt_ready = 1'b1;
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (expected_bases.size() == 0) begin
                    $error("output transaction with no prediction pending");
                    n_errors = n_errors + 1;
                end else begin
                    e = expected_bases.pop_front();
                    for (int i = 0; i < 9; i++) begin
                        if (o_m_axis_tdata[i*Q14_W +: Q14_W] !== e.rows[i]) begin
                            $error("%s: expected %0d, got %0d", field_names[i],
                                   $signed(e.rows[i]),
                                   $signed(o_m_axis_tdata[i*Q14_W +: Q14_W]));
                            n_errors = n_errors + 1;
                        end
                    end
                    if (o_m_axis_tuser[0] !== e.degen) begin
                        $error("%s: expected %0d, got %0d", field_names[9],
                               e.degen, o_m_axis_tuser[0]);
                        n_errors = n_errors + 1;
                    end
                    if (e.degen) n_degen = n_degen + 1;
                end
                n_checked = n_checked + 1;
                if (n_checked % 83 == 0) sink_burst <= ~sink_burst;
                wait_cycles = draw_wait(sink_burst);
                if (wait_cycles != 0) begin
                    nxt_ready = 1'b0;
                    sink_stall <= wait_cycles - 1;
                end else begin
                    sink_stall <= 0;
                end
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                nxt_ready = 1'b0;
            end else if (!hold_done && n_sent >= 300) begin
                hold_done <= 1'b1;
                hold_left <= 12 * LATENCY;
                nxt_ready = 1'b0;
            end else if (sink_stall > 0) begin
                sink_stall <= sink_stall - 1;
                nxt_ready = 1'b0;
            end
            i_m_axis_tready <= nxt_ready;
        end
    end

    initial begin
        n_sent    = 0;
        n_checked = 0;
        n_degen   = 0;
        n_errors  = 0;
        @(posedge i_rst_n);
        @(posedge i_clk);
        while (pending_reqs.size() > 0 || i_s_axis_tvalid || expected_bases.size() > 0)
            @(posedge i_clk);
        repeat (LATENCY + 20) @(posedge i_clk);
        $display("Checked %0d matrices, %0d of them degenerate (zero or parallel rows).",
                 n_checked, n_degen);
        $display("Random gaps on both sides plus one long output hold-off were applied.");
        if (n_errors == 0 && expected_bases.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("Timed out with %0d predictions outstanding.", expected_bases.size());
        $display("FAIL");
        $finish;
    end

endmodule
